// ===== rtl/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants of the sine pulse pixel color block
// Widths, register codes, reset values, reciprocal constants and the
// brightness tables built at elaboration from a fixed-point sine series.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int unsigned SINE_STEPS   = 1024;
  localparam int unsigned MAX_PIXELS   = 1024;
  localparam int unsigned PALETTE_SIZE = 5;
  localparam int unsigned NUM_PAL_REGS = 5;

  localparam int unsigned SINE_BITS   = $clog2(SINE_STEPS);
  localparam int unsigned QUART_BITS  = SINE_BITS - 2;
  localparam int unsigned QUART_STEPS = SINE_STEPS / 4;

  localparam int unsigned PIX_W      = 10;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CYC_W      = 16;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned NUM_CH     = COLOR_W / CH_W;
  localparam int unsigned BRIGHT_W   = 9;
  localparam int unsigned ENTRY_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned FRONT_STAGES = 2;
  localparam int unsigned PH_STAGES    = SINE_BITS + 1;
  localparam int unsigned SHADE_STAGES = 2;
  localparam int unsigned LATENCY      = FRONT_STAGES + TIME_W + PH_STAGES + SHADE_STAGES;

  // floor(x * MUL >> SH) equals floor(x / d) over the full input range
  localparam int unsigned DIV3_PIX_MUL = 683;
  localparam int unsigned DIV3_PIX_SH  = 11;
  localparam int unsigned DIV5_PIX_MUL = 205;
  localparam int unsigned DIV5_PIX_SH  = 10;
  localparam int unsigned DIV3_CYC_MUL = 43691;
  localparam int unsigned DIV3_CYC_SH  = 17;
  localparam int unsigned DIV5_CYC_MUL = 52429;
  localparam int unsigned DIV5_CYC_SH  = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_COUNT   = 3'd0,
    CFG_CYCLE_LENGTH  = 3'd1,
    CFG_PALETTE_ZERO  = 3'd2,
    CFG_PALETTE_ONE   = 3'd3,
    CFG_PALETTE_TWO   = 3'd4,
    CFG_PALETTE_THREE = 3'd5,
    CFG_PALETTE_FOUR  = 3'd6
  } cfg_reg_e;

  localparam logic [CNT_W-1:0] COUNT_RESET = 3'd5;
  localparam logic [CYC_W-1:0] CYCLE_RESET = 16'd1000;
  localparam logic [NUM_PAL_REGS-1:0][COLOR_W-1:0] PAL_RESET = {
    24'hE44E04, 24'h940101, 24'hD20000, 24'hDE3207, 24'hC10909
  };

  typedef struct packed {
    logic [CNT_W-1:0]                     count;
    logic [CYC_W-1:0]                     cycle;
    logic [NUM_PAL_REGS-1:0][COLOR_W-1:0] palette;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic [TIME_W-1:0]  tm;
    logic [ENTRY_W-1:0] entry;
    logic [CYC_W-1:0]   seg;
  } front1_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic [TIME_W-1:0]  tm;
    logic [CYC_W-1:0]   shift;
    logic [COLOR_W-1:0] color;
  } front_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic [TIME_W-1:0]  tm;
    logic [CYC_W-1:0]   rem;
    logic [CYC_W-1:0]   shift;
    logic [COLOR_W-1:0] color;
  } tmod_t;

  typedef struct packed {
    logic [PIX_W-1:0]     pix;
    logic [COLOR_W-1:0]   color;
    logic [CYC_W-1:0]     rem;
    logic [SINE_BITS-1:0] k;
  } phase_t;

  localparam logic [63:0] HALF_PI_Q30 = 64'h0000_0000_6487_ED51;
  localparam logic [63:0] Q30_ONE     = 64'h0000_0000_4000_0000;
  localparam logic [63:0] TOL         = 64'h0000_0000_0000_4000;

  // sin of (pi/2)*a/SINE_STEPS in Q30 by a truncated nested series
  function automatic logic [63:0] sin_q30(input logic [63:0] a);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] d;
    x  = (HALF_PI_Q30 * a) / SINE_STEPS;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    d  = ((x2 * t) >> 30) / 64'd156;
    t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d  = ((x2 * t) >> 30) / 64'd110;
    t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d  = ((x2 * t) >> 30) / 64'd72;
    t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d  = ((x2 * t) >> 30) / 64'd42;
    t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d  = ((x2 * t) >> 30) / 64'd20;
    t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    d  = ((x2 * t) >> 30) / 64'd6;
    t  = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    return (x * t) >> 30;
  endfunction

  function automatic logic [BRIGHT_W-1:0] bright_of(input logic [63:0] a, input logic neg);
    logic [63:0] m;
    logic [63:0] v;
    m = 64'd128 * sin_q30(a);
    if (!neg) begin
      v = 64'd128 + ((m + TOL) >> 30);
    end else if (m <= TOL) begin
      v = 64'd128;
    end else begin
      v = 64'd128 - ((m - TOL + Q30_ONE - 64'd1) >> 30);
    end
    return v[BRIGHT_W-1:0];
  endfunction

  function automatic logic [QUART_STEPS*BRIGHT_W-1:0] bright_tab(input logic neg);
    logic [QUART_STEPS*BRIGHT_W-1:0] tab;
    tab = '0;
    for (int j = 0; j < QUART_STEPS; j++) begin
      tab[j*BRIGHT_W +: BRIGHT_W] = bright_of(64'(4 * j), neg);
    end
    return tab;
  endfunction

  localparam logic [QUART_STEPS*BRIGHT_W-1:0] POS_TAB = bright_tab(1'b0);
  localparam logic [QUART_STEPS*BRIGHT_W-1:0] NEG_TAB = bright_tab(1'b1);
  localparam logic [BRIGHT_W-1:0] POS_FULL = bright_of(64'(SINE_STEPS), 1'b0);
  localparam logic [BRIGHT_W-1:0] NEG_FULL = bright_of(64'(SINE_STEPS), 1'b1);

endpackage

// ===== rtl/spc_front.sv =====
// ----------------------------------------------------------------------------
// spc_front: palette entry and phase offset
// Two stages: entry = pixel mod count and segment = cycle / count by
// shifts or reciprocal multiplies, then the offset product and the palette pick.
// ----------------------------------------------------------------------------
module spc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [spc_pkg::PIX_W-1:0]  pix_i,
  input  logic [spc_pkg::TIME_W-1:0] tm_i,
  input  spc_pkg::cfg_t              cfg_i,
  output logic                       valid_o,
  output spc_pkg::front_t            data_o
);
  import spc_pkg::*;

  logic [2*PIX_W-1:0] p3_prod;
  logic [2*PIX_W-1:0] p5_prod;
  logic [PIX_W-1:0]   p3_q;
  logic [PIX_W-1:0]   p5_q;
  logic [PIX_W-1:0]   p6_q;
  logic [2*CYC_W-1:0] c3_prod;
  logic [2*CYC_W-1:0] c5_prod;
  logic [CYC_W-1:0]   c3_q;
  logic [CYC_W-1:0]   c5_q;
  logic [PIX_W-1:0]   rem;

  front1_t s1_d;
  front1_t s1_q;
  logic    s1_valid_q;
  front_t  s2_d;
  front_t  s2_q;
  logic    s2_valid_q;
  logic    pal_ok;
  logic    on_strip;

  always_comb begin
    p3_prod = {{PIX_W{1'b0}}, pix_i} * (2*PIX_W)'(DIV3_PIX_MUL);
    p5_prod = {{PIX_W{1'b0}}, pix_i} * (2*PIX_W)'(DIV5_PIX_MUL);
    p3_q    = PIX_W'(p3_prod >> DIV3_PIX_SH);
    p5_q    = PIX_W'(p5_prod >> DIV5_PIX_SH);
    p6_q    = p3_q >> 1;
    c3_prod = {{CYC_W{1'b0}}, cfg_i.cycle} * (2*CYC_W)'(DIV3_CYC_MUL);
    c5_prod = {{CYC_W{1'b0}}, cfg_i.cycle} * (2*CYC_W)'(DIV5_CYC_MUL);
    c3_q    = CYC_W'(c3_prod >> DIV3_CYC_SH);
    c5_q    = CYC_W'(c5_prod >> DIV5_CYC_SH);
    rem     = '0;
    s1_d.seg = cfg_i.cycle;
    unique case (cfg_i.count)
      3'd2: begin
        rem      = {{(PIX_W-1){1'b0}}, pix_i[0]};
        s1_d.seg = cfg_i.cycle >> 1;
      end
      3'd3: begin
        rem      = pix_i - PIX_W'(p3_q * 3'd3);
        s1_d.seg = c3_q;
      end
      3'd4: begin
        rem      = {{(PIX_W-2){1'b0}}, pix_i[1:0]};
        s1_d.seg = cfg_i.cycle >> 2;
      end
      3'd5: begin
        rem      = pix_i - PIX_W'(p5_q * 3'd5);
        s1_d.seg = c5_q;
      end
      3'd6: begin
        rem      = pix_i - PIX_W'(p6_q * 3'd6);
        s1_d.seg = c3_q >> 1;
      end
      default: begin
        rem      = '0;
        s1_d.seg = cfg_i.cycle;
      end
    endcase
    s1_d.pix   = pix_i;
    s1_d.tm    = tm_i;
    s1_d.entry = rem[ENTRY_W-1:0];
  end

  always_comb begin
    pal_ok      = 32'(s1_q.entry) < NUM_PAL_REGS;
    on_strip    = 32'(s1_q.pix) < MAX_PIXELS;
    s2_d.pix    = s1_q.pix;
    s2_d.tm     = s1_q.tm;
    s2_d.shift  = s1_q.seg * CYC_W'(s1_q.entry);
    s2_d.color  = (pal_ok && on_strip) ? cfg_i.palette[s1_q.entry] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
  end

  assign valid_o = s2_valid_q;
  assign data_o  = s2_q;

endmodule

// ===== rtl/spc_tmod.sv =====
// ----------------------------------------------------------------------------
// spc_tmod: time modulo cycle
// Restoring remainder pipeline, one time bit per stage.
// ----------------------------------------------------------------------------
module spc_tmod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  spc_pkg::front_t           data_i,
  input  logic [spc_pkg::CYC_W-1:0] cycle_i,
  output logic                      valid_o,
  output spc_pkg::tmod_t            data_o
);
  import spc_pkg::*;

  tmod_t             st_d [TIME_W];
  tmod_t             st_q [TIME_W];
  logic [TIME_W-1:0] valid_q;

  always_comb begin
    tmod_t          prev;
    logic [CYC_W:0] trial;
    for (int i = 0; i < TIME_W; i++) begin
      if (i == 0) begin
        prev.pix   = data_i.pix;
        prev.tm    = data_i.tm;
        prev.rem   = '0;
        prev.shift = data_i.shift;
        prev.color = data_i.color;
      end else begin
        prev = st_q[i-1];
      end
      trial      = {prev.rem, prev.tm[TIME_W-1]};
      st_d[i]    = prev;
      st_d[i].tm = prev.tm << 1;
      if (trial >= {1'b0, cycle_i}) begin
        st_d[i].rem = CYC_W'(trial - {1'b0, cycle_i});
      end else begin
        st_d[i].rem = CYC_W'(trial);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[TIME_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TIME_W; i++) begin
      st_q[i] <= st_d[i];
    end
  end

  assign valid_o = valid_q[TIME_W-1];
  assign data_o  = st_q[TIME_W-1];

endmodule

// ===== rtl/spc_phase.sv =====
// ----------------------------------------------------------------------------
// spc_phase: shifted phase and sine step
// Adds the offset modulo the cycle, then forms the step index
// floor(u * SINE_STEPS / cycle) one quotient bit per stage.
// ----------------------------------------------------------------------------
module spc_phase (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  spc_pkg::tmod_t            data_i,
  input  logic [spc_pkg::CYC_W-1:0] cycle_i,
  output logic                      valid_o,
  output spc_pkg::phase_t           data_o
);
  import spc_pkg::*;

  phase_t               st_d [PH_STAGES];
  phase_t               st_q [PH_STAGES];
  logic [PH_STAGES-1:0] valid_q;

  always_comb begin
    phase_t         prev;
    logic [CYC_W:0] sum;
    logic [CYC_W:0] trial;
    sum = {1'b0, data_i.rem} + {1'b0, data_i.shift};
    st_d[0].pix   = data_i.pix;
    st_d[0].color = data_i.color;
    st_d[0].k     = '0;
    if (sum >= {1'b0, cycle_i}) begin
      st_d[0].rem = CYC_W'(sum - {1'b0, cycle_i});
    end else begin
      st_d[0].rem = CYC_W'(sum);
    end
    for (int i = 1; i < PH_STAGES; i++) begin
      prev    = st_q[i-1];
      trial   = {prev.rem, 1'b0};
      st_d[i] = prev;
      if (trial >= {1'b0, cycle_i}) begin
        st_d[i].rem = CYC_W'(trial - {1'b0, cycle_i});
        st_d[i].k   = {prev.k[SINE_BITS-2:0], 1'b1};
      end else begin
        st_d[i].rem = CYC_W'(trial);
        st_d[i].k   = {prev.k[SINE_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[PH_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PH_STAGES; i++) begin
      st_q[i] <= st_d[i];
    end
  end

  assign valid_o = valid_q[PH_STAGES-1];
  assign data_o  = st_q[PH_STAGES-1];

endmodule

// ===== rtl/spc_shade.sv =====
// ----------------------------------------------------------------------------
// spc_shade: brightness lookup and channel scaling
// Folds the step into one quadrant, reads the brightness table, then
// scales each channel by brightness / 256 into the output register.
// ----------------------------------------------------------------------------
module spc_shade (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  spc_pkg::phase_t             data_i,
  output logic                        result_valid_o,
  output logic [spc_pkg::PIX_W-1:0]   out_pixel_index_o,
  output logic [spc_pkg::COLOR_W-1:0] pixel_color_o
);
  import spc_pkg::*;

  logic [QUART_BITS-1:0] offs;
  logic [QUART_BITS-1:0] idx;
  logic                  odd;
  logic                  neg;
  logic                  full;
  logic [BRIGHT_W-1:0]   bright_d;

  logic                  a_valid_q;
  logic [PIX_W-1:0]      a_pix_q;
  logic [COLOR_W-1:0]    a_color_q;
  logic [BRIGHT_W-1:0]   a_bright_q;

  logic [COLOR_W-1:0]    color_d;
  logic                  out_valid_q;
  logic [PIX_W-1:0]      out_pix_q;
  logic [COLOR_W-1:0]    out_color_q;

  always_comb begin
    offs = data_i.k[QUART_BITS-1:0];
    odd  = data_i.k[SINE_BITS-2];
    neg  = data_i.k[SINE_BITS-1];
    idx  = odd ? QUART_BITS'(~offs + 1'b1) : offs;
    full = odd && (offs == '0);
    if (full) begin
      bright_d = neg ? NEG_FULL : POS_FULL;
    end else if (neg) begin
      bright_d = NEG_TAB[idx*BRIGHT_W +: BRIGHT_W];
    end else begin
      bright_d = POS_TAB[idx*BRIGHT_W +: BRIGHT_W];
    end
  end

  always_comb begin
    logic [CH_W+BRIGHT_W-1:0] prod;
    color_d = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      prod = {{BRIGHT_W{1'b0}}, a_color_q[c*CH_W +: CH_W]} *
             {{CH_W{1'b0}}, a_bright_q};
      color_d[c*CH_W +: CH_W] = prod[CH_W +: CH_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= valid_i;
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_pix_q     <= data_i.pix;
    a_color_q   <= data_i.color;
    a_bright_q  <= bright_d;
    out_pix_q   <= a_pix_q;
    out_color_q <= color_d;
  end

  assign result_valid_o    = out_valid_q;
  assign out_pixel_index_o = out_pix_q;
  assign pixel_color_o     = out_color_q;

endmodule

// ===== rtl/sine_pulse_pixel_color.sv =====
// ----------------------------------------------------------------------------
// sine_pulse_pixel_color: sine breathing color for one LED pixel
// Takes one pixel and time per clock and returns its faded palette color.
// ----------------------------------------------------------------------------
// One pixel enters per clock and busy stays low, so start may be held high
// for a continuous stream. Each result appears on the result ports with
// result_valid_o for exactly one cycle, in input order; the receiver must
// take it then. The pipeline is made of two front stages, the 32-stage
// time-modulo-cycle remainder pipeline, one offset stage, the 10-stage sine
// step quotient pipeline and two shading stages. Write configuration only
// while no pixel is in flight.
module sine_pulse_pixel_color (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [spc_pkg::PIX_W-1:0]     pixel_index_i,
  input  logic [spc_pkg::TIME_W-1:0]    time_ms_i,
  input  logic                          cfg_we_i,
  input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                          result_valid_o,
  output logic [spc_pkg::PIX_W-1:0]     out_pixel_index_o,
  output logic [spc_pkg::COLOR_W-1:0]   pixel_color_o
);
  import spc_pkg::*;

  logic [CNT_W-1:0]                     count_q;
  logic [CYC_W-1:0]                     cycle_q;
  logic [NUM_PAL_REGS-1:0][COLOR_W-1:0] palette_q;
  cfg_t                                 cfg;

  logic   front_valid;
  front_t front_data;
  logic   tmod_valid;
  tmod_t  tmod_data;
  logic   phase_valid;
  phase_t phase_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= COUNT_RESET;
      cycle_q   <= CYCLE_RESET;
      palette_q <= PAL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_COLOR_COUNT:   count_q      <= cfg_data_i[CNT_W-1:0];
        CFG_CYCLE_LENGTH:  cycle_q      <= cfg_data_i[CYC_W-1:0];
        CFG_PALETTE_ZERO:  palette_q[0] <= cfg_data_i[COLOR_W-1:0];
        CFG_PALETTE_ONE:   palette_q[1] <= cfg_data_i[COLOR_W-1:0];
        CFG_PALETTE_TWO:   palette_q[2] <= cfg_data_i[COLOR_W-1:0];
        CFG_PALETTE_THREE: palette_q[3] <= cfg_data_i[COLOR_W-1:0];
        CFG_PALETTE_FOUR:  palette_q[4] <= cfg_data_i[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp count to 1..PALETTE_SIZE and treat a zero cycle as one
  always_comb begin
    if (count_q == '0) begin
      cfg.count = CNT_W'(1);
    end else if (count_q > CNT_W'(PALETTE_SIZE)) begin
      cfg.count = CNT_W'(PALETTE_SIZE);
    end else begin
      cfg.count = count_q;
    end
    cfg.cycle   = (cycle_q == '0) ? CYC_W'(1) : cycle_q;
    cfg.palette = palette_q;
  end

  assign busy = 1'b0;

  spc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .pix_i   (pixel_index_i),
    .tm_i    (time_ms_i),
    .cfg_i   (cfg),
    .valid_o (front_valid),
    .data_o  (front_data)
  );

  spc_tmod u_tmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .data_i  (front_data),
    .cycle_i (cfg.cycle),
    .valid_o (tmod_valid),
    .data_o  (tmod_data)
  );

  spc_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tmod_valid),
    .data_i  (tmod_data),
    .cycle_i (cfg.cycle),
    .valid_o (phase_valid),
    .data_o  (phase_data)
  );

  spc_shade u_shade (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (phase_valid),
    .data_i            (phase_data),
    .result_valid_o    (result_valid_o),
    .out_pixel_index_o (out_pixel_index_o),
    .pixel_color_o     (pixel_color_o)
  );

  a_result_follows: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY result_valid_o
  ) else $error("transfer not followed by a result at the pipeline latency");

  a_result_origin: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(start && !busy, LATENCY) &&
                        out_pixel_index_o == $past(pixel_index_i, LATENCY))
  ) else $error("result without a matching transfer");

endmodule
